[rtl/core/wspg_pkg.sv]
// ----------------------------------------------------------------------------
// wspg_pkg
// Shared types, constants and helpers for the wheel speed P governor.
// ----------------------------------------------------------------------------
`default_nettype none

package wspg_pkg;

    // Item kinds carried on tuser
    localparam logic [1:0] FUNC_SETPOINT = 2'd0;
    localparam logic [1:0] FUNC_LEFT     = 2'd1;
    localparam logic [1:0] FUNC_RIGHT    = 2'd2;

    // Register index of the proportional gain
    localparam logic REG_KP = 1'b0;

    // Command limit, +-14 in Q8.8
    localparam int SPEED_LIMIT = 3584;

    // Frames without correction after a zero setpoint
    localparam logic [2:0] SETTLE_FRAMES = 3'd5;
    localparam logic [2:0] SETTLE_MAX    = 3'd7;

    // Speed scale 31250 * 256 = 15625 * 2^9
    localparam int SCALE_ODD   = 15625;
    localparam int SCALE_SHIFT = 9;

    // Divider geometry
    localparam int DSUM_W  = 33;
    localparam int PROD_W  = DSUM_W + 14;
    localparam int REM_W   = PROD_W + SCALE_SHIFT;
    localparam int QUO_W   = 15;
    localparam logic [QUO_W-1:0] MAG_MAX = {QUO_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_WAIT,
        ST_GAIN,
        ST_CORR,
        ST_OUT
    } gov_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_STEP
    } div_state_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] mag;
    } div_rsp_t;

    // Saturate an 18-bit signed value to 16 bits
    function automatic logic signed [15:0] sat16_18(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Saturate a 25-bit signed value to 16 bits
    function automatic logic signed [15:0] sat16_25(input logic signed [24:0] v);
        logic signed [15:0] r;
        if (v > 25'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -25'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Clamp a 17-bit signed value to the command range
    function automatic logic signed [12:0] clamp_cmd(input logic signed [16:0] v);
        logic signed [12:0] r;
        if (v > 17'(SPEED_LIMIT)) begin
            r = 13'(SPEED_LIMIT);
        end else if (v < -17'(SPEED_LIMIT)) begin
            r = -13'(SPEED_LIMIT);
        end else begin
            r = v[12:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/wspg_div.sv]
// ----------------------------------------------------------------------------
// wspg_div
// Measured speed magnitude: min(floor(dsum * 8000000 / dt), 32767), one
// scaling multiply then a shared subtract unit stepped one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wspg_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [wspg_pkg::DSUM_W-1:0]  dsum,
    input  wire logic [31:0]                  dt,
    output wspg_pkg::div_rsp_t                rsp
);
    import wspg_pkg::*;

    div_state_t        dv_state_reg, dv_state_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [REM_W-1:0]  dvs_reg, dvs_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [DSUM_W-1:0] dsum_reg, dsum_next;
    logic [31:0]       dt_reg, dt_next;
    logic              done_reg, done_next;

    logic [PROD_W-1:0] scaled;
    logic [REM_W:0]    diff;
    logic              ge;

    // Scaling multiply and shared subtract unit
    assign scaled = PROD_W'(dsum_reg) * PROD_W'(SCALE_ODD);
    assign diff   = {1'b0, rem_reg} - {1'b0, dvs_reg};
    assign ge     = ~diff[REM_W];

    // Next state
    always_comb begin
        dv_state_next = dv_state_reg;
        case (dv_state_reg)
            DV_IDLE: begin
                if (start) dv_state_next = DV_MUL;
            end
            DV_MUL:  dv_state_next = DV_STEP;
            DV_STEP: begin
                if ((cnt_reg == 4'd15 && ge) || cnt_reg == 4'd0) dv_state_next = DV_IDLE;
            end
            default: dv_state_next = DV_IDLE;
        endcase
    end

    // Datapath
    always_comb begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        dsum_next = dsum_reg;
        dt_next   = dt_reg;
        done_next = 1'b0;
        case (dv_state_reg)
            DV_IDLE: begin
                if (start) begin
                    dsum_next = dsum;
                    dt_next   = dt;
                end
            end
            DV_MUL: begin
                // Load dividend and divisor, the divisor aligned to the overflow bit above the top quotient bit
                rem_next = {scaled, {SCALE_SHIFT{1'b0}}};
                dvs_next = REM_W'({dt_reg, 15'b0});
                quo_next = '0;
                cnt_next = 4'd15;
            end
            DV_STEP: begin
                if (cnt_reg == 4'd15) begin
                    // Top bit set means the quotient overflows the magnitude range
                    if (ge) begin
                        quo_next  = MAG_MAX;
                        done_next = 1'b1;
                    end
                end else begin
                    if (ge) rem_next = diff[REM_W-1:0];
                    quo_next = {quo_reg[QUO_W-2:0], ge};
                    if (cnt_reg == 4'd0) done_next = 1'b1;
                end
                dvs_next = dvs_reg >> 1;
                cnt_next = cnt_reg - 4'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_state_reg <= DV_IDLE;
            done_reg     <= 1'b0;
        end else begin
            dv_state_reg <= dv_state_next;
            done_reg     <= done_next;
        end
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quo_reg  <= quo_next;
        dsum_reg <= dsum_next;
        dt_reg   <= dt_next;
    end

    assign rsp.done = done_reg;
    assign rsp.mag  = quo_reg;

    // Checks
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> dv_state_reg == DV_IDLE) else $error("divider started while busy");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |=> !rsp.done) else $error("divider done longer than one cycle");
    a_step_run: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_state_reg == DV_STEP && cnt_reg != 4'd15 && cnt_reg != 4'd0
        |=> dv_state_reg == DV_STEP) else $error("divider left early");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> dv_state_reg == DV_IDLE) else $error("done while busy");

endmodule

`default_nettype wire

[rtl/core/wheel_speed_p_governor_core.sv]
// ----------------------------------------------------------------------------
// wheel_speed_p_governor_core
// Proportional wheel speed governor: stores setpoint and left samples, and on
// each right sample emits a clamped Q8.8 speed command.
// ----------------------------------------------------------------------------
// Setpoint, left and unused items are taken in the idle state and leave the input ready.
// A right item goes straight to the output state when correction is skipped, and
// otherwise first passes multiply, 16 divide steps, gain and correction.
// The input is ready again once the result is registered; a right item whose result finds the
// previous one still waiting holds in its output state until that one is taken.
// Synchronous active-low reset clears the state, kp, stored samples, settle count and the output valid.
`default_nettype none

module wheel_speed_p_governor_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [79:0] s_tdata,  // setpoint[15:0], tick_count[47:16], timestamp_us[79:48]
    input  wire logic [1:0]  s_tuser,  // func[1:0]
    // Result channel
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata,  // speed_cmd[12:0], zero pad [15:13]
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);
    import wspg_pkg::*;

    gov_state_t         state_reg, state_next;
    logic [15:0]        kp_reg, kp_next;
    logic signed [15:0] sp_reg, sp_next;
    logic [31:0]        lticks_reg, lticks_next;
    logic [31:0]        ltime_reg, ltime_next;
    logic [31:0]        pl_ticks_reg, pl_ticks_next;
    logic [31:0]        pr_ticks_reg, pr_ticks_next;
    logic [31:0]        ptime_reg, ptime_next;
    logic [2:0]         settle_reg, settle_next;
    logic signed [12:0] cmd_reg, cmd_next;
    logic signed [32:0] prod_reg, prod_next;
    logic               mvalid_reg, mvalid_next;
    logic signed [12:0] mdata_reg, mdata_next;

    logic               in_acc;
    logic [1:0]         func;
    logic signed [15:0] in_sp;
    logic [31:0]        in_ticks, in_stamp;
    logic [32:0]        tsum;
    logic [31:0]        now, dt;
    logic [31:0]        dl, dr;
    logic [DSUM_W-1:0]  dsum;
    logic [2:0]         settle_eff;
    logic               skip, in_range, go_div;
    logic               div_start;
    div_rsp_t           div_rsp;
    logic signed [15:0] dev, corr;
    logic               cfg_wr;

    // Unpack the input item
    assign func     = s_tuser;
    assign in_sp    = s_tdata[15:0];
    assign in_ticks = s_tdata[47:16];
    assign in_stamp = s_tdata[79:48];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // Right sample front end
    assign tsum       = {1'b0, ltime_reg} + {1'b0, in_stamp};
    assign now        = tsum[32:1];
    assign dt         = now - ptime_reg;
    assign dl         = lticks_reg - pl_ticks_reg;
    assign dr         = in_ticks - pr_ticks_reg;
    assign dsum       = {1'b0, dl} + {1'b0, dr};
    assign settle_eff = (sp_reg == 16'sd0) ? 3'd0 : settle_reg;
    assign skip       = (settle_eff <= SETTLE_FRAMES) || (dt == 32'd0);
    assign in_range   = (sp_reg < 16'sd0) && (sp_reg >= -16'(SPEED_LIMIT));
    assign go_div     = in_acc && func == FUNC_RIGHT && !skip && in_range;
    assign div_start  = go_div;

    wspg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dsum    (dsum),
        .dt      (dt),
        .rsp     (div_rsp)
    );

    // Gain and correction terms
    assign dev  = sat16_18(18'(sp_reg) + 18'($signed({3'b0, div_rsp.mag})));
    assign corr = sat16_25(prod_reg[32:8]);

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_KP);
    assign prdata = (paddr[2] == REG_KP) ? {16'b0, kp_reg} : 32'b0;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && func == FUNC_RIGHT) state_next = go_div ? ST_DIV_WAIT : ST_OUT;
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) state_next = ST_GAIN;
            end
            ST_GAIN: state_next = ST_CORR;
            ST_CORR: state_next = ST_OUT;
            ST_OUT: begin
                if (!mvalid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        kp_next       = cfg_wr ? pwdata[15:0] : kp_reg;
        sp_next       = sp_reg;
        lticks_next   = lticks_reg;
        ltime_next    = ltime_reg;
        pl_ticks_next = pl_ticks_reg;
        pr_ticks_next = pr_ticks_reg;
        ptime_next    = ptime_reg;
        settle_next   = settle_reg;
        cmd_next      = cmd_reg;
        prod_next     = prod_reg;
        mvalid_next   = mvalid_reg && !m_tready;
        mdata_next    = mdata_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    case (func)
                        FUNC_SETPOINT: sp_next = in_sp;
                        FUNC_LEFT: begin
                            lticks_next = in_ticks;
                            ltime_next  = in_stamp;
                        end
                        FUNC_RIGHT: begin
                            // Count settle frames, hold the uncorrected command
                            if (skip) begin
                                settle_next = (settle_eff < SETTLE_MAX) ?
                                              settle_eff + 3'd1 : SETTLE_MAX;
                            end else begin
                                settle_next = settle_eff;
                            end
                            cmd_next      = clamp_cmd(17'(sp_reg));
                            pl_ticks_next = lticks_reg;
                            pr_ticks_next = in_ticks;
                            ptime_next    = now;
                        end
                        default: ;
                    endcase
                end
            end
            ST_GAIN: prod_next = $signed({1'b0, kp_reg}) * dev;
            ST_CORR: cmd_next = clamp_cmd(17'(sp_reg) + 17'(corr));
            ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = cmd_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            kp_reg       <= '0;
            sp_reg       <= '0;
            lticks_reg   <= '0;
            ltime_reg    <= '0;
            pl_ticks_reg <= '0;
            pr_ticks_reg <= '0;
            ptime_reg    <= '0;
            settle_reg   <= '0;
            mvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            kp_reg       <= kp_next;
            sp_reg       <= sp_next;
            lticks_reg   <= lticks_next;
            ltime_reg    <= ltime_next;
            pl_ticks_reg <= pl_ticks_next;
            pr_ticks_reg <= pr_ticks_next;
            ptime_reg    <= ptime_next;
            settle_reg   <= settle_next;
            mvalid_reg   <= mvalid_next;
        end
        cmd_reg   <= cmd_next;
        prod_reg  <= prod_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {3'b0, mdata_reg};

    // Checks
    a_div_to_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV_WAIT && div_rsp.done |=> state_reg == ST_GAIN)
        else $error("divider result missed");
    a_cmd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[12:0]) <= 13'sd3584 &&
                      $signed(m_tdata[12:0]) >= -13'sd3584 && m_tdata[15:13] == 3'b0))
        else $error("command out of range");
    a_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && func != FUNC_RIGHT |=> state_reg == ST_IDLE)
        else $error("non-right item started work");
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

endmodule

`default_nettype wire
